// File: rtl/core/first_prime_in_stream_core_macros.svh
// assertion macros used by the top level core module
`ifndef FIRST_PRIME_IN_STREAM_CORE_MACROS_SVH
`define FIRST_PRIME_IN_STREAM_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define FPIS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define FPIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fpis_pkg.sv
// shared types and constants of the first prime in stream core
package fpis_pkg;

    // width of the value fields on the ports
    localparam int FIELD_WIDTH = 32;

    // one input element
    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] value;
        logic                          last;
    } item_t;

    // one sequence result
    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] first_prime;
        logic                          found;
    } result_t;

endpackage

// File: rtl/core/fpis_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module fpis_div #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [VALUE_WIDTH-1:0] remainder
);
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [VALUE_WIDTH-1:0] den_reg;

    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   diff;
    logic                   qbit;
    logic [VALUE_WIDTH-1:0] rem_next;

    // one restoring step: shift in the next dividend bit and try to subtract
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        diff      = rem_shift - {1'b0, den_reg};
        qbit      = ~diff[VALUE_WIDTH];
        rem_next  = qbit ? diff[VALUE_WIDTH-1:0] : rem_shift[VALUE_WIDTH-1:0];
    end

    // control: step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(VALUE_WIDTH - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath: partial remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[VALUE_WIDTH-2:0], qbit};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/first_prime_in_stream_core.sv
// top level of the first prime in stream core
//
// Input channel item (item_valid, item_stall) carries one signed element and
// a last flag; a transfer happens when item_valid is high and item_stall low.
// Output channel result (result_valid, result_stall) carries one result per
// sequence, sent after the element marked last: the first prime seen, or all
// ones with found low when the sequence held none.
// Each element is tested by trial division with odd divisors 3, 5, 7, ...
// while the divisor does not exceed the quotient. Every trial runs through
// one bit-serial divider; an odd element to test goes from idle through the
// trial state, one divider run per trial, to the finish state. Elements that
// need no trial (negative, even, below 2, or once a prime is kept) go from
// idle straight to the finish state.
// item_stall is high while an element is being processed; one item at a time.
// A finished result waits in an output register; a stalled receiver only
// holds back the next last element, not ordinary ones.
// Reset (rst_n low, asynchronous) forgets any kept prime and empties the
// output register; the state also clears after each result is produced.
`include "first_prime_in_stream_core_macros.svh"

module first_prime_in_stream_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  fpis_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output fpis_pkg::result_t result
);
    import fpis_pkg::*;

    localparam int EXT_W = VALUE_WIDTH + FIELD_WIDTH;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_TEST   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [VALUE_WIDTH-1:0] FIRST_DIV = VALUE_WIDTH'(3);
    localparam logic [VALUE_WIDTH-1:0] DIV_STEP  = VALUE_WIDTH'(2);
    localparam logic [VALUE_WIDTH-1:0] SMALLEST  = VALUE_WIDTH'(2);
    localparam logic [EXT_W-1:0] NONE_WIDE = EXT_W'({VALUE_WIDTH{1'b1}});
    localparam logic [FIELD_WIDTH-1:0] NONE_VALUE = NONE_WIDE[FIELD_WIDTH-1:0];

    logic [1:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;
    logic                   last_reg, last_next;
    logic                   prime_reg, prime_next;
    logic                   have_prime_reg, have_prime_next;
    logic [VALUE_WIDTH-2:0] kept_reg, kept_next;
    logic                   result_valid_reg, result_valid_next;
    result_t                result_reg, result_next;

    logic [EXT_W-1:0]       item_wide;
    logic [VALUE_WIDTH-1:0] item_raw;
    logic                   accept;
    logic                   need_test;
    logic                   quick_prime;
    logic                   out_free;
    logic                   keep_now;
    logic [EXT_W-1:0]       kept_wide;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_divisor;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;

    // element taken as VALUE_WIDTH bits, sign-extended from the port field
    assign item_wide = EXT_W'(item.value);
    assign item_raw  = item_wide[VALUE_WIDTH-1:0];

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;

    // quick classification: only odd values of 3 or more need trials
    assign need_test   = !have_prime_reg && !item_raw[VALUE_WIDTH-1]
                         && item_raw[0] && (item_raw > SMALLEST);
    assign quick_prime = !have_prime_reg && (item_raw == SMALLEST);

    // shared trial divider
    assign div_dividend = (state_reg == ST_IDLE) ? item_raw : val_reg;
    assign div_divisor  = (state_reg == ST_IDLE) ? FIRST_DIV : div_reg + DIV_STEP;

    fpis_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // keep the first prime of the sequence
    assign keep_now  = prime_reg && !have_prime_reg;
    assign kept_wide = EXT_W'(keep_now ? val_reg[VALUE_WIDTH-2:0] : kept_reg);

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        val_next          = val_reg;
        div_next          = div_reg;
        last_next         = last_reg;
        prime_next        = prime_reg;
        have_prime_next   = have_prime_reg;
        kept_next         = kept_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        div_start         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    val_next   = item_raw;
                    last_next  = item.last;
                    prime_next = quick_prime;
                    div_next   = FIRST_DIV;
                    div_start  = need_test;
                    state_next = need_test ? ST_TEST : ST_FINISH;
                end
            end
            ST_TEST:
            begin
                if (div_done)
                begin
                    if (div_reg > div_quo)
                    begin
                        prime_next = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else if (div_rem == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_next  = div_reg + DIV_STEP;
                        div_start = 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!last_reg)
                begin
                    if (keep_now)
                    begin
                        have_prime_next = 1'b1;
                        kept_next       = val_reg[VALUE_WIDTH-2:0];
                    end
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next.found = have_prime_reg || keep_now;
                    result_next.first_prime = (have_prime_reg || keep_now)
                                              ? kept_wide[FIELD_WIDTH-1:0]
                                              : NONE_VALUE;
                    have_prime_next = 1'b0;
                    kept_next       = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            have_prime_reg   <= 1'b0;
            kept_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            have_prime_reg   <= have_prime_next;
            kept_reg         <= kept_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // working registers of the element in flight and the output payload
    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        div_reg    <= div_next;
        last_reg   <= last_next;
        prime_reg  <= prime_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    `FPIS_ASSERT_NEXT(a_accept_busy, accept, state_reg != ST_IDLE, "accepted item left core idle")
    `FPIS_ASSERT_SAME(a_test_odd, state_reg == ST_TEST, !have_prime_reg && div_reg[0], "bad trial state")
    `FPIS_ASSERT_SAME(a_none_value, result_valid && !result.found, result.first_prime == NONE_VALUE, "bad none value")
    `FPIS_ASSERT_NEXT(a_clear_after, state_reg == ST_FINISH && last_reg && out_free, !have_prime_reg && result_valid, "state not cleared")

endmodule
